>>> rtl/wpd_pkg.sv
// Shared types and constants for the window peak detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package wpd_pkg;

	// Deepest window the cell row can hold, in samples
	localparam int MAX_WINDOW = 63;
	// Largest half-width that fits the row
	localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 24;
	localparam int CFG_W  = 6;
	localparam int HALF_W = $clog2(HALF_MAX + 1);
	localparam int CELL_W = $clog2(MAX_WINDOW);

	localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(3);
	localparam logic [IDX_W-1:0] CNT_MAX  = {IDX_W{1'b1}};

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]         count_t;
	typedef logic [HALF_W-1:0]        half_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic cmp_en;      // cell lies in the span and is not the centre
		logic centre_sel;  // cell holds the centre sample
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/wpd_cell.sv
// One cell of the sample row: holds one sample, passes it on at each request,
// and compares it against the broadcast centre. Depends on wpd_pkg.
`default_nettype none

module wpd_cell
	import wpd_pkg::*;
(
	input  wire       clk,
	input  wire       shift_en,
	input  sample_t   d,
	input  sample_t   centre,
	input  cell_ctl_t ctl,
	output sample_t   q,
	output logic      gt,
	output sample_t   tap
);

	sample_t val_q;

	// Advance the row on an accepted request
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

	// Centre must beat this cell when the cell is inside the span
	assign gt = !ctl.cmp_en || (centre > val_q);

	// Offer this sample as the centre when selected
	assign tap = ctl.centre_sel ? val_q : sample_t'(0);

endmodule

`default_nettype wire

>>> rtl/window_peak_detector.sv
// A result is registered and shown in the cycle after its sample request is accepted.
// Throughput: one sample per cycle; input stalls only while a result waits
// and the output side is not taking it. The check is done in the accept
// cycle by the cell row compares against the broadcast centre.
// Reset (arst_n low): clears the set count, the held result and sets
// window_size to 3; the sample cells are not cleared.
`default_nettype none

module window_peak_detector
	import wpd_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire  [CFG_W-1:0]  cfg_wr_data,
	input  wire               in_valid,
	output logic              in_ready,
	input  sample_t           sample,
	input  wire               last,
	output logic              out_valid,
	input  wire               out_ready,
	output count_t            peak_index,
	output sample_t           peak_value
);

	logic [CFG_W-1:0] ws_q;
	count_t           cnt_q;
	logic             out_valid_q;
	count_t           peak_index_q;
	sample_t          peak_value_q;

	logic             accept;
	half_t            half;
	logic [CELL_W-1:0] twice_half;
	count_t           span;
	count_t           cnt_next;
	sample_t          centre;
	logic             detect;

	sample_t          cell_q   [MAX_WINDOW];
	sample_t          cell_tap [MAX_WINDOW];
	cell_ctl_t        cell_ctl [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] cell_gt;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_wr_en) begin
			ws_q <= cfg_wr_data;
		end
	end

	// Half-width, limited to what the row holds
	always_comb begin
		if (int'(ws_q[CFG_W-1:1]) > HALF_MAX) begin
			half = HALF_W'(HALF_MAX);
		end else begin
			half = HALF_W'(ws_q[CFG_W-1:1]);
		end
	end

	assign twice_half = CELL_W'({half, 1'b0});
	assign span       = IDX_W'({half, 1'b1});
	assign cnt_next   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + count_t'(1);

	// Cell row: cell i holds the sample that sits at span position i+1
	generate
		for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
			localparam logic [CELL_W-1:0] POS = CELL_W'(i);
			logic sel;

			assign sel = (half != half_t'(0)) &&
				(POS == CELL_W'(half) - CELL_W'(1));
			assign cell_ctl[i] = {(POS < twice_half) && !sel, sel};

			if (i == 0) begin : g_head
				wpd_cell u_cell (
					.clk      (clk),
					.shift_en (accept),
					.d        (sample),
					.centre   (centre),
					.ctl      (cell_ctl[i]),
					.q        (cell_q[i]),
					.gt       (cell_gt[i]),
					.tap      (cell_tap[i])
				);
			end else begin : g_body
				wpd_cell u_cell (
					.clk      (clk),
					.shift_en (accept),
					.d        (cell_q[i-1]),
					.centre   (centre),
					.ctl      (cell_ctl[i]),
					.q        (cell_q[i]),
					.gt       (cell_gt[i]),
					.tap      (cell_tap[i])
				);
			end
		end
	endgenerate

	// Pick the centre: the incoming sample when half is zero, else one cell
	always_comb begin
		centre = sample_t'(0);
		if (half == half_t'(0)) begin
			centre = sample;
		end else begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				centre = centre | cell_tap[i];
			end
		end
	end

	// Peak test over the span after this sample enters
	assign detect = (ws_q != '0) && (cnt_next >= span) && (&cell_gt) &&
		((half == half_t'(0)) || (centre > sample));

	// Set count: advance per request, drop at end of set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last ? count_t'(0) : cnt_next;
		end
	end

	// Result register: load on a detected peak, free when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= detect;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && detect) begin
			peak_index_q <= cnt_next - count_t'(1) - IDX_W'(half);
			peak_value_q <= centre;
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_index = peak_index_q;
	assign peak_value = peak_value_q;

endmodule

`default_nettype wire

>>> rtl/wpd_checker.sv
// Port-level checks for the window peak detector, bound to the top level.
// Depends on wpd_pkg.
`default_nettype none

module wpd_checker
	import wpd_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              cfg_wr_en,
	input wire [CFG_W-1:0]  cfg_wr_data,
	input wire              in_valid,
	input wire              in_ready,
	input wire [DATA_W-1:0] sample,
	input wire              last,
	input wire              out_valid,
	input wire              out_ready,
	input wire [IDX_W-1:0]  peak_index,
	input wire [DATA_W-1:0] peak_value
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(peak_index) &&
		$stable(peak_value))
		else $error("stalled result changed");

	// Input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// A new result follows an accepted request
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without request");

	// A taken result is not repeated without a new request
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result repeated");

endmodule

bind window_peak_detector wpd_checker u_wpd_checker (.*);

`default_nettype wire
